// ----- rtl/tgad_pkg.sv -----
package tgad_pkg;

   // field and register widths
   localparam int BYTE_W     = 8;
   localparam int PIXEL_W    = 32;
   localparam int COUNT_W    = 25;
   localparam int BPP_W      = 3;
   localparam int RUN_W      = 8;
   localparam int CARRIED_W  = 2;

   // command queue between the parser and the expander
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 25;
   localparam logic [CSR_ADDR_W-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_COUNT     = 1'd1;

   localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 25'd1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RAW,
      PH_RUN
   } phase_type;

   typedef struct packed {
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [COUNT_W-1:0] pixel_count;
   } cfg_type;

   // one decoded pixel plus how many copies to emit and the final flags
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [RUN_W-1:0]   pixels;
      logic               packet_last;
      logic               image_last;
      logic               overrun;
   } cmd_type;

endpackage

// ----- rtl/tgad_front.sv -----
module tgad_front (
   input  logic                     clock,
   input  logic                     reset,
   input  tgad_pkg::cfg_type        cfg,
   input  logic                     accept,
   input  logic [tgad_pkg::BYTE_W-1:0] stream_byte,
   output logic                     push,
   output tgad_pkg::cmd_type        cmd
);
   import tgad_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [RUN_W-1:0]   left_ff, left_in;
   logic [1:0]         pos_ff, pos_in;
   logic [PIXEL_W-1:0] gather_ff, gather_in;
   logic [COUNT_W-1:0] done_ff, done_in;

   logic [BPP_W-1:0]   bpp_eff;
   logic [COUNT_W-1:0] count_eff;
   logic [COUNT_W-1:0] avail;
   logic [PIXEL_W-1:0] merged;
   logic               complete;
   logic [RUN_W-1:0]   raw_left;
   logic               raw_reached;
   logic               run_err;
   logic [RUN_W-1:0]   run_n;
   logic               run_reached;

   // effective register values
   always_comb begin
      case (cfg.bytes_per_pixel) inside
         3'd0:                    bpp_eff = 3'd1;
         3'd1, 3'd2, 3'd3, 3'd4:  bpp_eff = cfg.bytes_per_pixel;
         default:                 bpp_eff = 3'd4;
      endcase
   end

   assign count_eff = (cfg.pixel_count == '0) ? COUNT_RESET : cfg.pixel_count;

   // pixels still owed to the image
   assign avail = (count_eff > done_ff) ? (count_eff - done_ff) : COUNT_W'(1);

   // byte gathering
   assign merged   = gather_ff | (PIXEL_W'(stream_byte) << {pos_ff, 3'b000});
   assign complete = ({1'b0, pos_ff} + 3'd1) >= bpp_eff;

   // packet bookkeeping
   assign raw_left    = left_ff - RUN_W'(1);
   assign raw_reached = avail <= COUNT_W'(1);
   assign run_err     = COUNT_W'(left_ff) > avail;
   assign run_n       = run_err ? avail[RUN_W-1:0] : left_ff;
   assign run_reached = COUNT_W'(run_n) >= avail;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         left_ff   <= '0;
         pos_ff    <= '0;
         gather_ff <= '0;
         done_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         gather_ff <= gather_in;
         done_ff   <= done_in;
      end
   end

   // packet parser
   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      gather_in = gather_ff;
      done_in   = done_ff;
      push      = 1'b0;
      cmd       = '0;
      cmd.pixel = merged;
      unique case (phase_ff) inside
         PH_HEADER: begin
            if (accept) begin
               // both packet kinds carry count-1 in the low seven bits
               phase_in  = stream_byte[BYTE_W-1] ? PH_RUN : PH_RAW;
               left_in   = {1'b0, stream_byte[BYTE_W-2:0]} + RUN_W'(1);
               pos_in    = '0;
               gather_in = '0;
            end
         end
         PH_RAW, PH_RUN: begin
            if (accept) begin
               if (!complete) begin
                  gather_in = merged;
                  pos_in    = pos_ff + 2'd1;
               end else begin
                  push      = 1'b1;
                  gather_in = '0;
                  pos_in    = '0;
                  if (phase_ff == PH_RAW) begin
                     cmd.pixels      = RUN_W'(1);
                     cmd.packet_last = (raw_left == '0) || raw_reached;
                     cmd.image_last  = raw_reached;
                     cmd.overrun     = raw_reached && (raw_left != '0);
                     left_in         = raw_left;
                     done_in         = raw_reached ? '0 : done_ff + COUNT_W'(1);
                     if (raw_reached || raw_left == '0) begin
                        phase_in = PH_HEADER;
                     end
                  end else begin
                     cmd.pixels      = run_n;
                     cmd.packet_last = 1'b1;
                     cmd.image_last  = run_reached;
                     cmd.overrun     = run_err;
                     done_in         = run_reached ? '0 : done_ff + COUNT_W'(left_ff);
                     phase_in        = PH_HEADER;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase
   end

endmodule

// ----- rtl/tgad_cmd_queue.sv -----
module tgad_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tgad_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output tgad_pkg::cmd_type head
);
   import tgad_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         mem [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = count_ff == CW'(QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/tgad_back.sv -----
module tgad_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  tgad_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tgad_pkg::PIXEL_W-1:0]     pixel_first,
   output logic [tgad_pkg::PIXEL_W-1:0]     pixel_second,
   output logic [tgad_pkg::CARRIED_W-1:0]   pixels_carried,
   output logic                             packet_last,
   output logic                             image_last,
   output logic                             overrun_error
);
   import tgad_pkg::*;

   // command being expanded
   logic               cur_valid_ff, cur_valid_in;
   cmd_type            cur_ff, cur_in;
   logic [RUN_W-1:0]   rem_ff, rem_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]   first_ff, first_in;
   logic [PIXEL_W-1:0]   second_ff, second_in;
   logic [CARRIED_W-1:0] carried_ff, carried_in;
   logic                 plast_ff, plast_in;
   logic                 ilast_ff, ilast_in;
   logic                 err_ff, err_in;

   logic                 load_out;
   logic                 emit;
   logic                 pair;
   logic [RUN_W-1:0]     rem_next;
   logic                 last;

   assign load_out = !rsp_valid_ff || rsp_tready;
   assign emit     = cur_valid_ff && load_out;
   assign pair     = rem_ff >= RUN_W'(2);
   assign rem_next = rem_ff - (pair ? RUN_W'(2) : RUN_W'(1));
   assign last     = rem_next == '0;
   assign cmd_pop  = cmd_valid && (!cur_valid_ff || (emit && last));

   // expansion control and result formation
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      first_in     = first_ff;
      second_in    = second_ff;
      carried_in   = carried_ff;
      plast_in     = plast_ff;
      ilast_in     = ilast_ff;
      err_in       = err_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         first_in     = cur_ff.pixel;
         second_in    = pair ? cur_ff.pixel : '0;
         carried_in   = pair ? CARRIED_W'(2) : CARRIED_W'(1);
         plast_in     = last && cur_ff.packet_last;
         ilast_in     = last && cur_ff.image_last;
         err_in       = last && cur_ff.overrun;
         rem_in       = rem_next;
         if (last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (cmd_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = cmd;
         rem_in       = cmd.pixels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      rem_ff     <= rem_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
      carried_ff <= carried_in;
      plast_ff   <= plast_in;
      ilast_ff   <= ilast_in;
      err_ff     <= err_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign pixel_first    = first_ff;
   assign pixel_second   = second_ff;
   assign pixels_carried = carried_ff;
   assign packet_last    = plast_ff;
   assign image_last     = ilast_ff;
   assign overrun_error  = err_ff;

endmodule

// ----- rtl/tga_rle_pixel_decoder.sv -----
// Targa RLE pixel stream decoder.
// req channel: one coded byte per transaction in req_tdata[7:0], packet
// headers and pixel bytes mixed as they appear in the image data.
// rsp channel: decoded pixels. A raw packet pixel comes out alone; a run
// packet is expanded into results of two pixels each, the last one holding
// one pixel when the run length is odd. rsp_tlast marks the result that
// completes the image; rsp_tuser carries packet last and overrun flags.
// csr port: index 0 bytes per pixel (1..4), index 1 pixel count per image.
// Write it only while no transaction is in flight.
// Throughput: one byte per cycle for headers and raw pixels. A run of N
// pixels occupies the expander for ceil(N/2) results; a two-entry command
// queue lets the parser keep taking bytes meanwhile and req_tready falls
// only when that queue is full.
// A completed pixel passes through the command queue, the expander's command
// register and the output register before its result appears.
// Reset clears the parser to await a packet header, empties the queue and
// the output register, and loads 4 bytes per pixel and a count of one.
// A stalled rsp side holds its result; the queue then fills and stalls req.
module tga_rle_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] stream_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [31:0] pixel_first, [63:32] pixel_second,
   //            [65:64] pixels_carried, [71:66] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: [0] packet_last, [1] overrun_error
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [tgad_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tgad_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tgad_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 accept;
   logic                 push;
   cmd_type              push_cmd;
   logic                 queue_full;
   logic                 queue_valid;
   cmd_type              queue_head;
   logic                 pop;
   logic [PIXEL_W-1:0]   pixel_first;
   logic [PIXEL_W-1:0]   pixel_second;
   logic [CARRIED_W-1:0] pixels_carried;
   logic                 packet_last;
   logic                 image_last;
   logic                 overrun_error;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[BPP_W-1:0];
            CSR_PIXEL_COUNT:     cfg_in.pixel_count     = csr_wdata[COUNT_W-1:0];
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= BPP_RESET;
         cfg_ff.pixel_count     <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   tgad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .stream_byte (req_tdata),
      .push        (push),
      .cmd         (push_cmd)
   );

   tgad_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .valid     (queue_valid),
      .head      (queue_head)
   );

   tgad_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (queue_valid),
      .cmd            (queue_head),
      .cmd_pop        (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .pixel_first    (pixel_first),
      .pixel_second   (pixel_second),
      .pixels_carried (pixels_carried),
      .packet_last    (packet_last),
      .image_last     (image_last),
      .overrun_error  (overrun_error)
   );

   // result packing
   assign rsp_tdata = {6'b0, pixels_carried, pixel_second, pixel_first};
   assign rsp_tlast = image_last;
   assign rsp_tuser = {overrun_error, packet_last};

`ifndef NO_ASSERTIONS
   // an overrun always ends the image
   a_overrun_ends_image: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overrun_error |-> image_last)
      else $error("overrun without image end");

   // the image ends only on a packet boundary
   a_image_end_on_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && image_last |-> packet_last)
      else $error("image end inside a packet");

   // no result straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a queued command never stays unserved while the expander is idle
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      queue_full |=> !queue_full || pop || $past(pop) || rsp_tvalid)
      else $error("command queue stuck");
`endif

endmodule

// ----- tb/sv/tga_rle_pixel_decoder_tb.sv -----
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_tb;
   import tgad_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned RANDOM_BYTES = 400;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_BYTES_PER_PIXEL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned req_calm_left = 0;
   bit          req_calm = 1'b0;

   // one decoded result as the block should present it
   typedef struct {
      logic [31:0] pixel_first;
      logic [31:0] pixel_second;
      logic [1:0]  pixels_carried;
      logic        packet_last;
      logic        image_last;
      logic        overrun_error;
   } decoded_pixels_type;

   // predicts decoded pixels per accepted byte and checks them in order
   class decoder_scoreboard;
      logic [BPP_W-1:0]   bpp_reg;
      logic [COUNT_W-1:0] count_reg;
      phase_type          phase;
      int unsigned        packet_left;
      int unsigned        byte_pos;
      logic [31:0]        gather;
      logic [COUNT_W-1:0] pixels_done;
      decoded_pixels_type pixels_due[$];
      int unsigned        mismatches;
      int unsigned        results_checked;
      int unsigned        raw_packets;
      int unsigned        run_packets;
      int unsigned        images;
      int unsigned        overruns;

      function new();
         bpp_reg = BPP_RESET;
         count_reg = COUNT_RESET;
         phase = PH_HEADER;
         packet_left = 0;
         byte_pos = 0;
         gather = '0;
         pixels_done = '0;
         mismatches = 0;
         results_checked = 0;
         raw_packets = 0;
         run_packets = 0;
         images = 0;
         overruns = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr == CSR_BYTES_PER_PIXEL) bpp_reg = data[BPP_W-1:0];
         else if (addr == CSR_PIXEL_COUNT) count_reg = data[COUNT_W-1:0];
      endfunction

      // zero acts as one, anything above four acts as four
      function int unsigned bytes_per_pixel();
         if (bpp_reg == 0) return 1;
         if (bpp_reg > 4) return 4;
         return bpp_reg;
      endfunction

      function int unsigned pending();
         return pixels_due.size();
      endfunction

      function void push_pixels(logic [31:0] pix, int unsigned carried, bit plast, bit ilast,
                                bit err);
         decoded_pixels_type r;
         r.pixel_first = pix;
         r.pixel_second = (carried == 2) ? pix : 32'h0;
         r.pixels_carried = carried[1:0];
         r.packet_last = plast;
         r.image_last = ilast;
         r.overrun_error = err;
         if (ilast) images++;
         if (err) overruns++;
         pixels_due.push_back(r);
      endfunction

      function void decode_byte(logic [7:0] b);
         int unsigned eff_count;
         int unsigned avail;
         int unsigned n;
         int unsigned c;
         logic [31:0] pix;
         bit reached;
         bit err;
         eff_count = (count_reg == 0) ? 1 : count_reg;

         // packet header: sets the kind and the length of the packet
         if (phase == PH_HEADER) begin
            if (b < 8'd128) begin
               phase = PH_RAW;
               packet_left = b + 1;
               raw_packets++;
            end else begin
               phase = PH_RUN;
               packet_left = b - 127;
               run_packets++;
            end
            byte_pos = 0;
            gather = '0;
            return;
         end

         // gather pixel bytes, low byte first
         gather = gather | (32'(b) << (8 * (byte_pos & 3)));
         if (byte_pos + 1 < bytes_per_pixel()) begin
            byte_pos = (byte_pos + 1) & 3;
            return;
         end
         pix = gather;
         byte_pos = 0;
         gather = '0;
         avail = (eff_count > pixels_done) ? eff_count - pixels_done : 1;
         if (packet_left == 0) packet_left = 1;

         // raw pixel goes out alone
         if (phase == PH_RAW) begin
            packet_left--;
            pixels_done = pixels_done + 1'b1;
            reached = (avail <= 1);
            err = reached && (packet_left != 0);
            push_pixels(pix, 1, (packet_left == 0) || reached, reached, err);
            if (reached) begin
               phase = PH_HEADER;
               packet_left = 0;
               pixels_done = '0;
            end else if (packet_left == 0) begin
               phase = PH_HEADER;
            end
            return;
         end

         // run pixel expands in pairs, cut at the image end
         err = packet_left > avail;
         n = err ? avail : packet_left;
         reached = (n >= avail);
         while (n > 0) begin
            c = (n >= 2) ? 2 : 1;
            n -= c;
            push_pixels(pix, c, n == 0, (n == 0) && reached, (n == 0) && err);
         end
         if (reached) pixels_done = '0;
         else pixels_done = pixels_done + COUNT_W'(packet_left);
         phase = PH_HEADER;
         packet_left = 0;
      endfunction

      function void check_result(logic [71:0] data, logic last, logic [1:0] user);
         decoded_pixels_type e;
         results_checked++;
         if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected result data=%h last=%b user=%b", data, last, user);
            return;
         end
         e = pixels_due.pop_front();
         if (data[31:0] !== e.pixel_first || data[63:32] !== e.pixel_second ||
             data[65:64] !== e.pixels_carried || data[71:66] !== 6'h0 ||
             last !== e.image_last || user[0] !== e.packet_last ||
             user[1] !== e.overrun_error) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("tb: result %0d mismatch", results_checked);
               $display("   expected first=%h second=%h carried=%0d",
                        e.pixel_first, e.pixel_second, e.pixels_carried);
               $display("            pkt_last=%b img_last=%b err=%b",
                        e.packet_last, e.image_last, e.overrun_error);
               $display("   actual   first=%h second=%h carried=%0d",
                        data[31:0], data[63:32], data[65:64]);
               $display("            pkt_last=%b img_last=%b err=%b pad=%h",
                        user[0], last, user[1], data[71:66]);
            end
         end
      endfunction
   endclass

   decoder_scoreboard sb = new();

   tga_rle_pixel_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // cycle counter and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // one byte transaction, with a random gap unless in a calm stretch
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (req_calm_left == 0) begin
         req_calm_left = $urandom_range(8, 40);
         req_calm = ($urandom_range(0, 2) == 0);
      end
      req_calm_left--;
      gap = req_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_seq(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // well-formed packet with random pixel content
   task automatic send_packet(input bit run, input int unsigned npix);
      int unsigned nbytes;
      send_byte(run ? 8'(127 + npix) : 8'(npix - 1));
      nbytes = (run ? 1 : npix) * sb.bytes_per_pixel();
      repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
   endtask

   // stop offering and let every expected result drain
   task automatic wait_idle(input int unsigned tail);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // both registers written on back-to-back edges
   task automatic write_config(input int unsigned bpp, input int unsigned count);
      csr_we <= 1'b1;
      csr_addr <= CSR_BYTES_PER_PIXEL;
      csr_wdata <= CSR_DATA_W'(bpp);
      @(posedge clock);
      sb.write_reg(CSR_BYTES_PER_PIXEL, CSR_DATA_W'(bpp));
      csr_addr <= CSR_PIXEL_COUNT;
      csr_wdata <= CSR_DATA_W'(count);
      @(posedge clock);
      sb.write_reg(CSR_PIXEL_COUNT, CSR_DATA_W'(count));
      csr_we <= 1'b0;
   endtask

   // result side: random stalls, calm stretches and one long hold-off
   initial begin : rsp_side
      int unsigned stall;
      int unsigned calm_left;
      bit calm;
      bit held;
      calm_left = 0;
      calm = 1'b0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (calm_left == 0) begin
            calm_left = $urandom_range(8, 40);
            calm = ($urandom_range(0, 2) == 0);
         end
         calm_left--;
         stall = calm ? 0 : $urandom_range(0, 5);
         // long hold-off starts while the sender is offering bytes
         if (!held && sb.results_checked >= 100 && req_tvalid) begin
            stall = HOLD_CYCLES;
            held = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // stimulus
   initial begin : req_side
      int unsigned bpp;
      int unsigned count;
      int unsigned start_bytes;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one four-byte pixel per image
      send_seq('{8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55});
      wait_idle(8);

      // zero bytes per pixel acts as one: run of two, raw of two, run overrun
      write_config(0, 5);
      send_seq('{8'h81, 8'hFF, 8'h01, 8'h00, 8'h80, 8'hFF, 8'h7F});
      wait_idle(8);

      // raw overrun: the rest of the packet is read as headers
      write_config(2, 2);
      send_seq('{8'h03, 8'h34, 8'h12, 8'hCD, 8'hAB});
      wait_idle(8);

      // count lowered below the pixels already done in the image
      write_config(7, 33554431);
      send_seq('{8'h82, 8'h01, 8'h02, 8'h03, 8'h04});
      wait_idle(8);
      write_config(7, 2);
      send_seq('{8'h80, 8'hFE, 8'hDC, 8'hBA, 8'h98});
      wait_idle(8);

      // random phases, one setting each
      start_bytes = bytes_sent;
      for (int p = 0; bytes_sent - start_bytes < RANDOM_BYTES; p++) begin
         case (p % 8)
            0: begin bpp = 1; count = $urandom_range(1, 12); end
            1: begin bpp = 3; count = $urandom_range(1, 40); end
            2: begin bpp = 4; count = 0; end
            3: begin bpp = 2; count = $urandom_range(20, 60); end
            4: begin bpp = $urandom_range(5, 7); count = 16777216; end
            5: begin bpp = 1; count = 1; end
            6: begin bpp = 0; count = $urandom_range(2, 8); end
            default: begin bpp = 4; count = 33554431; end
         endcase
         write_config(bpp, count);
         repeat (6 + $urandom_range(0, 6)) begin
            if ($urandom_range(0, 7) == 0)
               send_byte(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 9) == 0)
               send_packet($urandom_range(0, 1), $urandom_range(1, 128));
            else
               send_packet($urandom_range(0, 1), $urandom_range(1, 6));
         end
         // finish any packet left open so the next setting starts clean
         while (sb.phase != PH_HEADER) send_byte(8'($urandom_range(0, 255)));
         wait_idle(8);
      end

      wait_idle(DRAIN_CYCLES);
      $display("tb: %0d bytes in %0d raw and %0d run packets, %0d results checked",
               bytes_sent, sb.raw_packets, sb.run_packets, sb.results_checked);
      $display("tb: %0d images ended, %0d overruns, %0d mismatches",
               sb.images, sb.overruns, sb.mismatches);
      if (sb.mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ----- tga_rle_pixel_decoder.f -----
rtl/tgad_pkg.sv
rtl/tgad_front.sv
rtl/tgad_cmd_queue.sv
rtl/tgad_back.sv
rtl/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_tb.sv
